// File: rtl/dfusc_pkg.sv
// ----------------------------------------------------------------------------
// dfusc_pkg
// shared types, constants and the byte-wide crc-32 update for the suffix checker
// ----------------------------------------------------------------------------
package dfusc_pkg;

    // suffix window length in bytes
    localparam int unsigned SUFFIX_BYTES = 16;
    // a byte enters the crc once this many newer bytes have followed it
    localparam int unsigned CRC_LAG      = 4;
    localparam int unsigned COUNT_W      = $clog2(SUFFIX_BYTES + 1);

    localparam logic [31:0] CRC_START    = 32'hffff_ffff;
    localparam logic [31:0] CRC_POLY     = 32'hedb8_8320;

    localparam logic [15:0] MAX_VERSION_RESET = 16'h0100;
    localparam logic [31:0] SIGNATURE_RESET   = 32'h1044_4655;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_VERSION = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIGNATURE   = 8'd1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_VERSION   = 3'd1,
        ST_SIGNATURE = 3'd2,
        ST_CRC       = 3'd3,
        ST_SHORT     = 3'd4
    } status_t;

    // entry 0 oldest, top entry newest
    typedef logic [SUFFIX_BYTES-1:0][7:0] window_t;
    typedef logic [COUNT_W-1:0]           count_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] crc;
        logic [15:0] device;
        logic [15:0] product;
        logic [15:0] vendor;
        logic [15:0] version;
    } result_t;

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// File: rtl/dfusc_suffix_eval.sv
// ----------------------------------------------------------------------------
// dfusc_suffix_eval
// decodes the suffix window and runs the version, signature and crc checks
// ----------------------------------------------------------------------------
module dfusc_suffix_eval (
    input  dfusc_pkg::window_t  window,
    input  logic [31:0]         crc,
    input  logic                full,
    input  logic [15:0]         max_version,
    input  logic [31:0]         signature,
    output dfusc_pkg::result_t  result
);
    import dfusc_pkg::*;

    logic [15:0] version_w;
    logic [31:0] signature_w;
    logic [31:0] file_crc_w;

    assign version_w   = {window[7], window[6]};
    assign signature_w = {window[11], window[10], window[9], window[8]};
    assign file_crc_w  = {window[15], window[14], window[13], window[12]};

    // checks in file order, first failure wins
    always_comb begin
        priority if (!full) begin
            result.status = ST_SHORT;
        end else if (version_w > max_version) begin
            result.status = ST_VERSION;
        end else if (signature_w != signature) begin
            result.status = ST_SIGNATURE;
        end else if (file_crc_w != crc) begin
            result.status = ST_CRC;
        end else begin
            result.status = ST_OK;
        end
    end

    assign result.crc     = crc;
    assign result.device  = {window[1], window[0]};
    assign result.product = {window[3], window[2]};
    assign result.vendor  = {window[5], window[4]};
    assign result.version = version_w;

endmodule

// File: rtl/dfu_suffix_checker.sv
// ----------------------------------------------------------------------------
// dfu_suffix_checker
// streaming dfu suffix check: crc-32 over the image body plus suffix decode
// ----------------------------------------------------------------------------
// Takes one image byte per request, final byte flagged by s_is_last, and
// gives one result per image on the m_ channel. Sustained rate is one byte
// per clock; a result is presented once its final byte has passed the input
// register and then the result register, and can be taken at the following
// edge. The cycle is set by the byte-wide
// crc xor network feeding the 32-bit crc compare. Input stalls only when a
// final byte sits in the input register while an earlier result is still
// waiting to be taken. Each byte enters the crc once four newer bytes follow
// it, so the last four bytes (the stored crc) stay out. Images shorter than
// 16 bytes report status too-short with unfilled suffix bytes read as zero.
// After every result the crc, window and byte count return to reset values;
// configuration registers are kept. Configuration writes are always accepted,
// unknown indexes are ignored.
module dfu_suffix_checker (
    input  logic        aclk,
    input  logic        aresetn,

    // image byte requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_is_last,

    // result requests
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_computed_crc,
    output logic [15:0] m_device_word,
    output logic [15:0] m_product_word,
    output logic [15:0] m_vendor_word,
    output logic [15:0] m_version_word,

    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [dfusc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);
    import dfusc_pkg::*;

    // configuration registers
    logic [15:0] max_version_reg;
    logic [31:0] signature_reg;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;

    // image state
    logic [31:0] crc_reg, crc_next;
    window_t     window_reg, window_next;
    count_t      count_reg, count_next;

    // result register
    logic        out_valid_reg, out_valid_next;
    result_t     out_reg;
    result_t     eval_result;

    logic        s_accept;
    logic        advance;
    logic        crc_shifted;
    window_t     window_shifted;
    count_t      count_inc;
    logic [31:0] crc_upd;

    // a staged byte moves on unless it ends an image and the result slot is busy
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    assign cfg_ready = 1'b1;

    // configuration write decode
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_version_reg <= MAX_VERSION_RESET;
            signature_reg   <= SIGNATURE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_VERSION: max_version_reg <= cfg_data[15:0];
                REG_SIGNATURE:   signature_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_is_last;
        end
    end

    // byte that is now four places back joins the crc
    assign crc_shifted    = (count_reg >= COUNT_W'(CRC_LAG));
    assign crc_upd        = crc_shifted ? crc_byte(crc_reg, window_reg[SUFFIX_BYTES-CRC_LAG])
                                        : crc_reg;
    assign window_shifted = {in_byte_reg, window_reg[SUFFIX_BYTES-1:1]};
    assign count_inc      = (count_reg < COUNT_W'(SUFFIX_BYTES)) ? count_reg + 1'b1 : count_reg;

    // suffix checks on the window as it stands after this byte
    dfusc_suffix_eval u_eval (
        .window      (window_shifted),
        .crc         (crc_upd),
        .full        (count_inc == COUNT_W'(SUFFIX_BYTES)),
        .max_version (max_version_reg),
        .signature   (signature_reg),
        .result      (eval_result)
    );

    // image state: advance per byte, back to reset after the final one
    always_comb begin
        crc_next    = crc_reg;
        window_next = window_reg;
        count_next  = count_reg;
        if (advance) begin
            if (in_last_reg) begin
                crc_next    = CRC_START;
                window_next = '0;
                count_next  = '0;
            end else begin
                crc_next    = crc_upd;
                window_next = window_shifted;
                count_next  = count_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_START;
            window_reg <= '0;
            count_reg  <= '0;
        end else begin
            crc_reg    <= crc_next;
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

    // result register, loaded by the final byte of an image
    always_comb begin
        out_valid_next = out_valid_reg;
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_reg <= eval_result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_reg.status;
    assign m_computed_crc = out_reg.crc;
    assign m_device_word  = out_reg.device;
    assign m_product_word = out_reg.product;
    assign m_vendor_word  = out_reg.vendor;
    assign m_version_word = out_reg.version;

`ifndef SYNTHESIS
    // a final byte always leaves a result behind
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> out_valid_reg)
        else $error("final byte did not load a result");

    // image state is back at reset after a final byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_last_reg |=> (crc_reg == CRC_START) && (count_reg == '0))
        else $error("image state not cleared after result");

    // input stalls only behind a waiting result
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && in_last_reg && out_valid_reg)
        else $error("input stalled without a pending result");

    // byte count never passes the suffix length
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(SUFFIX_BYTES))
        else $error("byte count out of range");

    // a passing result never carries a version above the limit, unless the limit is written while it waits
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && (out_reg.status == ST_OK) |-> out_reg.version <= max_version_reg)
        else $error("ok status with version above limit");
`endif

endmodule
